### src/assert_macros.svh
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication checked every clock outside reset
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

### src/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg
// shared types and constants of the polygon plane clipper
// ----------------------------------------------------------------------------
package ppc_pkg;
	localparam int CW = 32;
	localparam int DW = 40;
	localparam int NW = 18;
	localparam int TW = 17;
	localparam int QBITS = 16;
	localparam int EPS = 655;
	localparam int TDW = 24;
	localparam logic [2:0] REG_NX = 3'd0;
	localparam logic [2:0] REG_NY = 3'd1;
	localparam logic [2:0] REG_NZ = 3'd2;
	localparam logic [2:0] REG_OFS = 3'd3;
	localparam logic [2:0] REG_KEEP = 3'd4;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_DIST, OP_SAVE_FIRST, OP_SAVE_PREV, OP_EDGE_SETUP,
		OP_DIV_START, OP_LERP, OP_EMIT_A, OP_EMIT_I, OP_CLOSE_SETUP, OP_EMPTY,
		OP_FLUSH_HELD
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic a_in;
		logic b_in;
		logic div_done;
		logic out_busy;
		logic held_valid;
	} sts_t;
endpackage

### src/ppc_datapath.sv
// ----------------------------------------------------------------------------
// ppc_datapath
// distance, serial t divider, interpolation and held-vertex output register
// ----------------------------------------------------------------------------
module ppc_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [31:0]                   cfg_data,
	input  logic [3*ppc_pkg::CW-1:0]      in_data,
	input  logic                          load_en,
	input  ppc_pkg::cmd_t                 cmd,
	output ppc_pkg::sts_t                 sts,
	output logic                          m_valid,
	input  logic                          m_ready,
	output logic [3*ppc_pkg::CW+1:0]      m_data
);
	localparam int CW = ppc_pkg::CW;
	localparam int DW = ppc_pkg::DW;
	localparam int TW = ppc_pkg::TW;

	logic signed [ppc_pkg::NW-1:0] nx_q, ny_q, nz_q;
	logic signed [31:0] ofs_q;
	logic keep_q;
	logic signed [CW-1:0] cx_q, cy_q, cz_q;
	logic signed [CW-1:0] fx_q, fy_q, fz_q, px_q, py_q, pz_q;
	logic signed [CW-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;
	logic signed [CW-1:0] hx_q, hy_q, hz_q;
	logic signed [DW-1:0] dc_q, df_q, dp_q, da_q, db_q;
	logic held_q;
	logic [1:0] dstep_q;
	logic signed [DW+ppc_pkg::QBITS+4:0] acc_q;
	logic [DW:0] rem_q, den_q;
	logic [TW-1:0] t_q;
	logic [4:0] dcnt_q;
	logic dbusy_q;
	logic [1:0] lstep_q;
	logic signed [CW-1:0] lx_q, ly_q, lz_q;
	logic ov_q;
	logic [3*CW+1:0] od_q;

	logic signed [DW+ppc_pkg::QBITS+4:0] prod;
	logic signed [CW-1:0] psel;
	logic signed [ppc_pkg::NW-1:0] nsel;
	logic signed [DW:0] num_w, den_w;
	logic [DW+1:0] rsh;
	logic signed [CW:0] dl;
	logic signed [CW+TW+1:0] lp;
	logic signed [CW-1:0] la, lres;
	logic signed [DW+ppc_pkg::QBITS+4:0] dsum;

	always_comb begin
		unique case (dstep_q)
			2'd0: begin psel = cx_q; nsel = nx_q; end
			2'd1: begin psel = cy_q; nsel = ny_q; end
			default: begin psel = cz_q; nsel = nz_q; end
		endcase
		prod = (DW+ppc_pkg::QBITS+5)'(psel) * (DW+ppc_pkg::QBITS+5)'(nsel);
		dsum = (acc_q >>> ppc_pkg::QBITS) + (DW+ppc_pkg::QBITS+5)'(ofs_q);
		num_w = (DW+1)'(da_q);
		den_w = (DW+1)'(da_q) - (DW+1)'(db_q);
		if (den_w < 0) begin
			num_w = -num_w;
			den_w = -den_w;
		end
		rsh = {rem_q, 1'b0};
		unique case (lstep_q)
			2'd0: begin dl = (CW+1)'(bx_q) - (CW+1)'(ax_q); la = ax_q; end
			2'd1: begin dl = (CW+1)'(by_q) - (CW+1)'(ay_q); la = ay_q; end
			default: begin dl = (CW+1)'(bz_q) - (CW+1)'(az_q); la = az_q; end
		endcase
		lp = (CW+TW+2)'(dl) * $signed((CW+TW+2)'({1'b0, t_q}));
		lres = la + CW'(lp >>> ppc_pkg::QBITS);
	end

	assign sts.a_in = da_q >= -DW'(ppc_pkg::EPS);
	assign sts.b_in = db_q >= -DW'(ppc_pkg::EPS);
	assign sts.div_done = !dbusy_q && (lstep_q == 2'd3);
	assign sts.out_busy = ov_q;
	assign sts.held_valid = held_q;
	assign m_valid = ov_q;
	assign m_data = od_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q <= '0; ny_q <= '0; nz_q <= 18'sd65536; ofs_q <= '0; keep_q <= 1'b1;
			held_q <= 1'b0; ov_q <= 1'b0; dbusy_q <= 1'b0; lstep_q <= 2'd3;
			dstep_q <= 2'd3;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					ppc_pkg::REG_NX: nx_q <= cfg_data[ppc_pkg::NW-1:0];
					ppc_pkg::REG_NY: ny_q <= cfg_data[ppc_pkg::NW-1:0];
					ppc_pkg::REG_NZ: nz_q <= cfg_data[ppc_pkg::NW-1:0];
					ppc_pkg::REG_OFS: ofs_q <= cfg_data;
					ppc_pkg::REG_KEEP: keep_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (load_en) begin
				cx_q <= in_data[CW-1:0];
				cy_q <= in_data[2*CW-1:CW];
				cz_q <= in_data[3*CW-1:2*CW];
			end
			if (ov_q && m_ready) ov_q <= 1'b0;
			if (dstep_q != 2'd3) begin
				acc_q <= acc_q + prod;
				dstep_q <= dstep_q + 2'd1;
			end
			if (dbusy_q) begin
				if (rsh >= {1'b0, den_q}) begin
					rem_q <= (DW+1)'(rsh - {1'b0, den_q});
					t_q <= {t_q[TW-2:0], 1'b1};
				end else begin
					rem_q <= rsh[DW:0];
					t_q <= {t_q[TW-2:0], 1'b0};
				end
				dcnt_q <= dcnt_q - 5'd1;
				if (dcnt_q == 5'd1) begin
					dbusy_q <= 1'b0;
					lstep_q <= 2'd0;
				end
			end else if (lstep_q != 2'd3) begin
				unique case (lstep_q)
					2'd0: lx_q <= lres;
					2'd1: ly_q <= lres;
					default: lz_q <= lres;
				endcase
				lstep_q <= lstep_q + 2'd1;
			end
			unique case (cmd.op)
				ppc_pkg::OP_LOAD: begin
					acc_q <= '0;
					dstep_q <= 2'd0;
				end
				ppc_pkg::OP_DIST: dc_q <= keep_q ? DW'(dsum) : -DW'(dsum);
				ppc_pkg::OP_SAVE_FIRST: begin
					fx_q <= cx_q; fy_q <= cy_q; fz_q <= cz_q; df_q <= dc_q;
					px_q <= cx_q; py_q <= cy_q; pz_q <= cz_q; dp_q <= dc_q;
				end
				ppc_pkg::OP_SAVE_PREV: begin
					px_q <= cx_q; py_q <= cy_q; pz_q <= cz_q; dp_q <= dc_q;
				end
				ppc_pkg::OP_EDGE_SETUP: begin
					ax_q <= px_q; ay_q <= py_q; az_q <= pz_q; da_q <= dp_q;
					bx_q <= cx_q; by_q <= cy_q; bz_q <= cz_q; db_q <= dc_q;
				end
				ppc_pkg::OP_CLOSE_SETUP: begin
					ax_q <= cx_q; ay_q <= cy_q; az_q <= cz_q; da_q <= dc_q;
					bx_q <= fx_q; by_q <= fy_q; bz_q <= fz_q; db_q <= df_q;
				end
				ppc_pkg::OP_DIV_START: begin
					if (num_w <= 0) begin
						t_q <= '0; lstep_q <= 2'd0;
					end else if (num_w >= den_w) begin
						t_q <= TW'(1 << ppc_pkg::QBITS); lstep_q <= 2'd0;
					end else begin
						rem_q <= num_w[DW:0]; den_q <= den_w[DW:0]; t_q <= '0;
						dcnt_q <= 5'd16; dbusy_q <= 1'b1;
					end
				end
				ppc_pkg::OP_EMIT_A, ppc_pkg::OP_EMIT_I: begin
					if (held_q) begin
						od_q <= {2'b00, hz_q, hy_q, hx_q};
						ov_q <= 1'b1;
					end
					held_q <= 1'b1;
					if (cmd.op == ppc_pkg::OP_EMIT_A) begin
						hx_q <= ax_q; hy_q <= ay_q; hz_q <= az_q;
					end else begin
						hx_q <= lx_q; hy_q <= ly_q; hz_q <= lz_q;
					end
				end
				ppc_pkg::OP_FLUSH_HELD: begin
					od_q <= {2'b01, hz_q, hy_q, hx_q};
					ov_q <= 1'b1;
					held_q <= 1'b0;
				end
				ppc_pkg::OP_EMPTY: begin
					od_q <= {2'b11, {3*CW{1'b0}}};
					ov_q <= 1'b1;
					held_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end
endmodule

### src/ppc_ctrl.sv
// ----------------------------------------------------------------------------
// ppc_ctrl
// sequencer for vertex intake, edge processing and result emission
// ----------------------------------------------------------------------------
module ppc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_valid,
	output logic          s_ready,
	input  logic          s_last,
	output logic          load_en,
	input  ppc_pkg::sts_t sts,
	output ppc_pkg::cmd_t cmd
);
	typedef enum logic [3:0] {
		IDLE, MUL, DIST, SORT, EDGE, CHECK, EMITA, DIVW, EMITI, FIN
	} state_t;
	state_t state_q;
	logic [1:0] seen_q;
	logic last_q, closing_q;
	logic [3:0] wait_q;

	assign s_ready = (state_q == IDLE) && (cmd.op == ppc_pkg::OP_NONE) && !sts.out_busy;
	assign load_en = s_valid && s_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE; seen_q <= '0; last_q <= 1'b0; closing_q <= 1'b0;
			wait_q <= '0; cmd <= '{op: ppc_pkg::OP_NONE};
		end else begin
			cmd.op <= ppc_pkg::OP_NONE;
			unique case (state_q)
				IDLE: if (s_valid && s_ready) begin
					cmd.op <= ppc_pkg::OP_LOAD; last_q <= s_last;
					wait_q <= 4'd4; state_q <= MUL;
				end
				MUL: if (wait_q == 4'd1) begin
					cmd.op <= ppc_pkg::OP_DIST; state_q <= SORT;
				end else wait_q <= wait_q - 4'd1;
				SORT: begin
					if (seen_q == 2'd0) begin
						cmd.op <= last_q ? ppc_pkg::OP_EMPTY : ppc_pkg::OP_SAVE_FIRST;
						seen_q <= last_q ? 2'd0 : 2'd1;
						state_q <= IDLE;
					end else if (seen_q == 2'd1 && last_q) begin
						cmd.op <= ppc_pkg::OP_EMPTY; seen_q <= 2'd0; state_q <= IDLE;
					end else begin
						cmd.op <= ppc_pkg::OP_EDGE_SETUP; closing_q <= 1'b0;
						state_q <= CHECK;
					end
				end
				CHECK: if (cmd.op == ppc_pkg::OP_NONE && !sts.out_busy) begin
					if (sts.a_in) cmd.op <= ppc_pkg::OP_EMIT_A;
					state_q <= EMITA;
				end
				EMITA: if (!sts.out_busy) begin
					if (sts.a_in != sts.b_in) begin
						cmd.op <= ppc_pkg::OP_DIV_START; state_q <= DIVW;
					end else state_q <= FIN;
				end
				DIVW: if (cmd.op == ppc_pkg::OP_NONE && sts.div_done) state_q <= EMITI;
				EMITI: if (!sts.out_busy) begin
					cmd.op <= ppc_pkg::OP_EMIT_I; state_q <= FIN;
				end
				FIN: if (cmd.op == ppc_pkg::OP_NONE && !sts.out_busy) begin
					if (last_q && !closing_q) begin
						cmd.op <= ppc_pkg::OP_CLOSE_SETUP; closing_q <= 1'b1;
						state_q <= CHECK;
					end else if (last_q) begin
						cmd.op <= sts.held_valid ? ppc_pkg::OP_FLUSH_HELD : ppc_pkg::OP_EMPTY;
						seen_q <= 2'd0; state_q <= IDLE;
					end else begin
						cmd.op <= ppc_pkg::OP_SAVE_PREV; seen_q <= 2'd2; state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

### src/polygon_plane_clip_core.sv
// ----------------------------------------------------------------------------
// polygon_plane_clip_core
// clips a convex polygon against one configured plane
// ----------------------------------------------------------------------------
// usage:
//  s_axis carries one vertex per transaction: tdata = x, y, z (32 bits each,
//  lowest first); tlast marks the final vertex of a polygon.
//  m_axis carries clipped vertices: tdata = out_x, out_y, out_z; tlast marks
//  the final vertex; tuser = empty_res (coordinates zero, tlast high).
//  cfg_we/cfg_index/cfg_data write the plane registers while idle.
//  one vertex at a time: a vertex is taken only after the previous one is fully
//  processed, the last vertex also processing the closing edge; each edge that
//  crosses the plane gets its t from the bit-serial t divider (skipped when t
//  clamps to 0 or 1) and its point from the shared interpolation multiplier.
//  one generated vertex is held back so the last result carries tlast.
//  reset clears the plane to z normal, keep front, and starts a new polygon.
//  a stalled m_axis holds the output register and blocks further intake.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module polygon_plane_clip_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,  // vertex_x, vertex_y, vertex_z
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,  // out_x, out_y, out_z
	output logic        m_axis_tlast,
	output logic        m_axis_tuser   // empty_res
);
	ppc_pkg::cmd_t cmd;
	ppc_pkg::sts_t sts;
	logic [3*ppc_pkg::CW+1:0] od;
	logic load_en;

	ppc_ctrl u_ctrl (
		.clk, .arst_n, .s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
		.s_last(s_axis_tlast), .load_en, .sts, .cmd
	);
	ppc_datapath u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .in_data(s_axis_tdata),
		.load_en, .cmd, .sts, .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
		.m_data(od)
	);
	assign m_axis_tdata = od[3*ppc_pkg::CW-1:0];
	assign m_axis_tlast = od[3*ppc_pkg::CW];
	assign m_axis_tuser = od[3*ppc_pkg::CW+1];

	`ASSERT_IMPL(a_empty_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
	`ASSERT_IMPL(a_no_intake_busy, m_axis_tvalid, !s_axis_tready)
	`ASSERT_NEXT(a_hold_stall, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule
